// ===== sv/nof_pkg.sv =====
`timescale 1ns / 1ps

package nof_pkg;

   localparam int CHAR_W        = 21;
   localparam int POS_W         = 17;
   localparam int CFG_W         = 16;
   localparam int CMD_W         = 2;
   localparam int STATUS_W      = 2;
   localparam int CSR_IDX_W     = 1;
   localparam int MAX_TOKEN_LEN = 32;
   localparam int MAX_TEXT_LEN  = 65535;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_END    = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TRIVIAL   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_START_CHAR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OCCURRENCE = 1'd1;

   localparam logic [CFG_W-1:0] OCCURRENCE_RESET = 16'd1;

   typedef struct packed {
      logic tok_shift;
      logic win_shift;
   } cell_ctrl_type;

endpackage

// ===== sv/nof_cell.sv =====
`timescale 1ns / 1ps

module nof_cell (
   input  logic                        clock,
   input  nof_pkg::cell_ctrl_type      ctrl,
   input  logic [nof_pkg::CHAR_W-1:0]  tok_prev,
   input  logic [nof_pkg::CHAR_W-1:0]  win_prev,
   output logic [nof_pkg::CHAR_W-1:0]  tok_out,
   output logic [nof_pkg::CHAR_W-1:0]  win_out,
   output logic                        eq_next
);

   logic [nof_pkg::CHAR_W-1:0] tok_ff;
   logic [nof_pkg::CHAR_W-1:0] tok_in;
   logic [nof_pkg::CHAR_W-1:0] win_ff;
   logic [nof_pkg::CHAR_W-1:0] win_in;

   // The window character arriving this cycle is checked against the
   // token character this cell holds.
   assign eq_next = (win_prev == tok_ff);
   assign tok_out = tok_ff;
   assign win_out = win_ff;

   always_comb begin
      tok_in = ctrl.tok_shift ? tok_prev : tok_ff;
      win_in = ctrl.win_shift ? win_prev : win_ff;
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      win_ff <= win_in;
   end

endmodule

// ===== sv/nth_token_occurrence_finder.sv =====
`timescale 1ns / 1ps

// Searches a stream of decoded code points for the Nth non-overlapping
// occurrence of a token. Input beats on the req_ channel carry a command:
// clear the token, append a token character, stream a text character, or
// end the text. Only an end-of-text beat produces a result beat on the
// rsp_ channel, with the match position and a status. The csr_ channel
// writes the start index and the wanted occurrence; it is always ready.
// The user must write it only while idle; the block does not enforce it.
// One input beat is taken every cycle unless req_stall holds an end-of-text
// beat. The token and text window sit in a row of MAX_TOKEN_LEN cells that
// shift one character per beat, and all cells compare in parallel, so the
// match decision for a text character is made in the cycle it is accepted.
// The result sits in an output register, and a second register catches
// one more result while the first is held by rsp_stall. Input beats keep
// flowing; an end-of-text beat is stalled only while both registers hold
// results, until the first one is taken.
// Reset is synchronous: the token becomes empty, all counters and flags
// clear, start_char returns to 0 and occurrence to 1.

module nth_token_occurrence_finder #(
   parameter int MAX_TOKEN_LEN = nof_pkg::MAX_TOKEN_LEN
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [nof_pkg::CMD_W-1:0]            req_command,
   input  logic [nof_pkg::CHAR_W-1:0]           req_char_value,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [nof_pkg::POS_W-1:0]     rsp_position,
   output logic [nof_pkg::STATUS_W-1:0]         rsp_status,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [nof_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [nof_pkg::CFG_W-1:0]            csr_data
);

   localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
   localparam int POS_W = nof_pkg::POS_W;
   localparam int CFG_W = nof_pkg::CFG_W;
   localparam int CHAR_W = nof_pkg::CHAR_W;

   logic [CFG_W-1:0]   start_char_ff,  start_char_in;
   logic [CFG_W-1:0]   occurrence_ff,  occurrence_in;
   logic [LEN_W-1:0]   token_length_ff, token_length_in;
   logic [POS_W-1:0]   text_index_ff,  text_index_in;
   logic [POS_W-1:0]   search_from_ff, search_from_in;
   logic [POS_W-1:0]   match_count_ff, match_count_in;
   logic [POS_W-1:0]   found_pos_ff,   found_pos_in;
   logic               found_ff,       found_in;
   logic               overflow_ff,    overflow_in;
   logic               rsp_valid_ff,   rsp_valid_in;
   logic signed [POS_W-1:0]          rsp_position_ff, rsp_position_in;
   logic [nof_pkg::STATUS_W-1:0]     rsp_status_ff,   rsp_status_in;
   logic               skid_valid_ff,  skid_valid_in;
   logic signed [POS_W-1:0]          skid_position_ff, skid_position_in;
   logic [nof_pkg::STATUS_W-1:0]     skid_status_ff,   skid_status_in;

   nof_pkg::cell_ctrl_type cell_ctrl;
   logic [CHAR_W-1:0]      tok_q [MAX_TOKEN_LEN];
   logic [CHAR_W-1:0]      win_q [MAX_TOKEN_LEN];
   logic [MAX_TOKEN_LEN-1:0] eq_vec;
   logic [MAX_TOKEN_LEN-1:0] len_mask;

   logic               req_accept;
   logic               end_fire;
   logic               rsp_take;
   logic               window_match;
   logic [POS_W-1:0]   next_index;
   logic [POS_W-1:0]   token_len_ext;
   logic [POS_W-1:0]   first_pos;
   logic [POS_W-1:0]   search_eff;
   logic [POS_W-1:0]   count_inc;
   logic signed [POS_W-1:0]          end_position;
   logic [nof_pkg::STATUS_W-1:0]     end_status;

   genvar k;
   generate
      for (k = 0; k < MAX_TOKEN_LEN; k++) begin : g_cell
         if (k == 0) begin : g_head
            nof_cell u_cell (
               .clock    (clock),
               .ctrl     (cell_ctrl),
               .tok_prev (req_char_value),
               .win_prev (req_char_value),
               .tok_out  (tok_q[k]),
               .win_out  (win_q[k]),
               .eq_next  (eq_vec[k])
            );
         end else begin : g_body
            nof_cell u_cell (
               .clock    (clock),
               .ctrl     (cell_ctrl),
               .tok_prev (tok_q[k-1]),
               .win_prev (win_q[k-1]),
               .tok_out  (tok_q[k]),
               .win_out  (win_q[k]),
               .eq_next  (eq_vec[k])
            );
         end
      end
   endgenerate

   always_comb begin
      for (int i = 0; i < MAX_TOKEN_LEN; i++) begin
         len_mask[i] = (LEN_W'(i) < token_length_ff);
      end
   end

   assign window_match = &(eq_vec | ~len_mask);

   assign req_stall  = skid_valid_ff & (req_command == nof_pkg::CMD_END);
   assign req_accept = req_valid & ~req_stall;
   assign end_fire   = req_accept & (req_command == nof_pkg::CMD_END);
   assign rsp_take   = rsp_valid_ff & ~rsp_stall;
   assign csr_ready  = 1'b1;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_status   = rsp_status_ff;

   assign next_index    = text_index_ff + POS_W'(1);
   assign token_len_ext = POS_W'(token_length_ff);
   assign first_pos     = next_index - token_len_ext;
   assign search_eff    = (text_index_ff == '0) ? POS_W'(start_char_ff) : search_from_ff;
   assign count_inc     = match_count_ff + POS_W'(1);

   always_comb begin
      if (overflow_ff) begin
         end_position = '1;
         end_status   = nof_pkg::STATUS_OVERFLOW;
      end else if (text_index_ff == '0 || token_length_ff == '0
                   || occurrence_ff == '0) begin
         end_position = '0;
         end_status   = nof_pkg::STATUS_TRIVIAL;
      end else if (POS_W'(start_char_ff) > text_index_ff) begin
         end_position = '1;
         end_status   = nof_pkg::STATUS_NOT_FOUND;
      end else if (found_ff) begin
         end_position = $signed(found_pos_ff);
         end_status   = nof_pkg::STATUS_FOUND;
      end else begin
         end_position = '1;
         end_status   = nof_pkg::STATUS_NOT_FOUND;
      end
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_position_in  = rsp_position_ff;
      rsp_status_in    = rsp_status_ff;
      skid_valid_in    = skid_valid_ff;
      skid_position_in = skid_position_ff;
      skid_status_in   = skid_status_ff;

      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_position_in = skid_position_ff;
            rsp_status_in   = skid_status_ff;
            skid_valid_in   = 1'b0;
         end
      end else if (end_fire) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in    = 1'b1;
            rsp_position_in = end_position;
            rsp_status_in   = end_status;
         end else begin
            skid_valid_in    = 1'b1;
            skid_position_in = end_position;
            skid_status_in   = end_status;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      start_char_in   = start_char_ff;
      occurrence_in   = occurrence_ff;
      token_length_in = token_length_ff;
      text_index_in   = text_index_ff;
      search_from_in  = search_from_ff;
      match_count_in  = match_count_ff;
      found_pos_in    = found_pos_ff;
      found_in        = found_ff;
      overflow_in     = overflow_ff;
      cell_ctrl       = '0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            nof_pkg::CSR_START_CHAR: start_char_in = csr_data;
            nof_pkg::CSR_OCCURRENCE: occurrence_in = csr_data;
            default: ;
         endcase
      end

      if (req_accept) begin
         case (req_command)
            nof_pkg::CMD_CLEAR: begin
               token_length_in = '0;
            end
            nof_pkg::CMD_APPEND: begin
               if (token_length_ff == LEN_W'(MAX_TOKEN_LEN)) begin
                  overflow_in = 1'b1;
               end else begin
                  cell_ctrl.tok_shift = 1'b1;
                  token_length_in     = token_length_ff + LEN_W'(1);
               end
            end
            nof_pkg::CMD_TEXT: begin
               if (text_index_ff == POS_W'(nof_pkg::MAX_TEXT_LEN)) begin
                  overflow_in = 1'b1;
               end else begin
                  cell_ctrl.win_shift = 1'b1;
                  text_index_in       = next_index;
                  search_from_in      = search_eff;
                  if (token_length_ff != '0 && next_index >= token_len_ext && !found_ff
                      && first_pos >= search_eff && window_match) begin
                     match_count_in = count_inc;
                     search_from_in = next_index;
                     if (count_inc == POS_W'(occurrence_ff)) begin
                        found_in     = 1'b1;
                        found_pos_in = first_pos;
                     end
                  end
               end
            end
            nof_pkg::CMD_END: begin
               text_index_in  = '0;
               search_from_in = '0;
               match_count_in = '0;
               found_pos_in   = '0;
               found_in       = 1'b0;
               overflow_in    = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_char_ff   <= '0;
         occurrence_ff   <= nof_pkg::OCCURRENCE_RESET;
         token_length_ff <= '0;
         text_index_ff   <= '0;
         search_from_ff  <= '0;
         match_count_ff  <= '0;
         found_pos_ff    <= '0;
         found_ff        <= 1'b0;
         overflow_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         start_char_ff   <= start_char_in;
         occurrence_ff   <= occurrence_in;
         token_length_ff <= token_length_in;
         text_index_ff   <= text_index_in;
         search_from_ff  <= search_from_in;
         match_count_ff  <= match_count_in;
         found_pos_ff    <= found_pos_in;
         found_ff        <= found_in;
         overflow_ff     <= overflow_in;
         rsp_valid_ff    <= rsp_valid_in;
         skid_valid_ff   <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_position_ff  <= rsp_position_in;
      rsp_status_ff    <= rsp_status_in;
      skid_position_ff <= skid_position_in;
      skid_status_ff   <= skid_status_in;
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import nof_pkg::*;

   localparam int HALF_PERIOD        = 4;
   localparam int RESET_CYCLES       = 9;
   localparam int SETTLE_CYCLES      = 4;
   localparam int RANDOM_BEATS       = 450;
   localparam int LONG_TEXT_EXTRA    = 2;
   localparam longint WATCHDOG_NS    = 100_000_000;

   localparam logic [CHAR_W-1:0] SYM_A    = 21'h00061;
   localparam logic [CHAR_W-1:0] SYM_B    = 21'h00062;
   localparam logic [CHAR_W-1:0] SYM_X    = 21'h00078;
   localparam logic [CHAR_W-1:0] SYM_FILL = 21'h00007;
   localparam logic [CHAR_W-1:0] CHAR_TOP = 21'h1FFFFF;

   typedef struct {
      logic [CMD_W-1:0]  command;
      logic [CHAR_W-1:0] char_value;
   } req_beat_type;

   typedef struct {
      logic signed [POS_W-1:0] position;
      logic [STATUS_W-1:0]     status;
   } search_result_type;

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_stall;
   logic [CMD_W-1:0]           req_command    = CMD_CLEAR;
   logic [CHAR_W-1:0]          req_char_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall      = 1'b0;
   logic signed [POS_W-1:0]    rsp_position;
   logic [STATUS_W-1:0]        rsp_status;
   logic                       csr_valid      = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index      = CSR_START_CHAR;
   logic [CFG_W-1:0]           csr_data       = '0;

   // Local copy of the search state, advanced on every accepted request beat.
   logic [CHAR_W-1:0] tok_chars [MAX_TOKEN_LEN];
   logic [CHAR_W-1:0] text_window [MAX_TOKEN_LEN];
   int unsigned       tok_len       = 0;
   int unsigned       text_len      = 0;
   int unsigned       search_pt     = 0;
   int unsigned       match_total   = 0;
   int unsigned       match_pos     = 0;
   bit                match_done    = 1'b0;
   bit                overflow_seen = 1'b0;
   logic [CFG_W-1:0]  cfg_start      = '0;
   logic [CFG_W-1:0]  cfg_occurrence = OCCURRENCE_RESET;

   req_beat_type      req_beats [$];
   search_result_type awaited_results [$];
   logic [CHAR_W-1:0] token_copy [$];
   logic [CHAR_W-1:0] alphabet [3];

   req_beat_type      next_beat;
   search_result_type due;
   int             error_count     = 0;
   int             beats_accepted  = 0;
   int             beats_queued    = 0;
   int             results_checked = 0;
   int             status_seen [4] = '{0, 0, 0, 0};
   int             req_gap         = 0;
   int             stall_left      = 0;
   bit             calm            = 1'b0;

   nth_token_occurrence_finder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_char_value (req_char_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_position   (rsp_position),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic logic [CHAR_W-1:0] any_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return CHAR_TOP;
      return CHAR_W'($urandom);
   endfunction

   function automatic void rearm_text();
      foreach (text_window[i]) text_window[i] = '0;
      text_len      = 0;
      search_pt     = 0;
      match_total   = 0;
      match_pos     = 0;
      match_done    = 1'b0;
      overflow_seen = 1'b0;
   endfunction

   function automatic bit window_holds_token(input int unsigned first);
      for (int unsigned j = 0; j < tok_len; j++) begin
         if (text_window[(first + j) % MAX_TOKEN_LEN] != tok_chars[j]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic advance_search(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch);
      int unsigned       first;
      search_result_type res;
      beats_accepted++;
      case (cmd)
         CMD_CLEAR: begin
            tok_len = 0;
         end
         CMD_APPEND: begin
            if (tok_len >= MAX_TOKEN_LEN) begin
               overflow_seen = 1'b1;
            end else begin
               tok_chars[tok_len] = ch;
               tok_len++;
            end
         end
         CMD_TEXT: begin
            if (text_len >= MAX_TEXT_LEN) begin
               overflow_seen = 1'b1;
            end else begin
               if (text_len == 0) search_pt = cfg_start;
               text_window[text_len % MAX_TOKEN_LEN] = ch;
               text_len++;
               if (tok_len > 0 && text_len >= tok_len && !match_done) begin
                  first = text_len - tok_len;
                  if (first >= search_pt && window_holds_token(first)) begin
                     match_total++;
                     search_pt = first + tok_len;
                     if (match_total == cfg_occurrence) begin
                        match_done = 1'b1;
                        match_pos  = first;
                     end
                  end
               end
            end
         end
         CMD_END: begin
            if (overflow_seen) begin
               res.position = '1;
               res.status   = STATUS_OVERFLOW;
            end else if (text_len == 0 || tok_len == 0 || cfg_occurrence == 0) begin
               res.position = '0;
               res.status   = STATUS_TRIVIAL;
            end else if (cfg_start > text_len) begin
               res.position = '1;
               res.status   = STATUS_NOT_FOUND;
            end else if (match_done) begin
               res.position = match_pos[POS_W-1:0];
               res.status   = STATUS_FOUND;
            end else begin
               res.position = '1;
               res.status   = STATUS_NOT_FOUND;
            end
            awaited_results = {awaited_results, res};
            rearm_text();
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_search(req_command, req_char_value);
            req_gap = pick_gap();
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0 || req_beats.size() == 0) begin
               if (req_gap > 0) req_gap--;
               req_valid <= 1'b0;
            end else begin
               next_beat = req_beats.pop_front();
               req_valid      <= 1'b1;
               req_command    <= next_beat.command;
               req_char_value <= next_beat.char_value;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected result beat: position %0d, status %0d",
                      rsp_position, rsp_status);
               error_count++;
            end else begin
               due = awaited_results.pop_front();
               if (rsp_position !== due.position) begin
                  $error("position mismatch: expected %0d, actual %0d",
                         due.position, rsp_position);
                  error_count++;
               end
               if (rsp_status !== due.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         due.status, rsp_status);
                  error_count++;
               end
               results_checked++;
               status_seen[due.status]++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = pick_gap();
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic add_beat(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch);
      req_beat_type b;
      b.command    = cmd;
      b.char_value = ch;
      req_beats = {req_beats, b};
      beats_queued++;
      if (cmd == CMD_CLEAR) begin
         token_copy.delete();
      end else if (cmd == CMD_APPEND && token_copy.size() < MAX_TOKEN_LEN) begin
         token_copy = {token_copy, ch};
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      bit taken;
      taken = 1'b0;
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      while (!taken) begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      if (idx == CSR_START_CHAR) cfg_start = value;
      else cfg_occurrence = value;
   endtask

   task automatic set_config(input logic [CFG_W-1:0] start, input logic [CFG_W-1:0] occ);
      write_csr(CSR_START_CHAR, start);
      write_csr(CSR_OCCURRENCE, occ);
   endtask

   // The block is idle once every queued beat is taken and every result has come back.
   task automatic settle();
      do @(negedge clock);
      while (req_beats.size() != 0 || req_valid || awaited_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int               r;
      int               n_sym;
      int               n_len;
      int               n_texts;
      int               n_chars;
      int               made;
      int               random_base;
      logic [CFG_W-1:0] st;
      logic [CFG_W-1:0] oc;

      rearm_text();
      n_sym = 2;
      alphabet[0] = SYM_A;
      alphabet[1] = SYM_B;
      alphabet[2] = SYM_X;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_config(16'd0, 16'd1);
      add_beat(CMD_END, CHAR_TOP);
      add_beat(CMD_APPEND, SYM_A);
      add_beat(CMD_APPEND, CHAR_TOP);
      add_beat(CMD_TEXT, '0);
      add_beat(CMD_TEXT, SYM_A);
      add_beat(CMD_TEXT, CHAR_TOP);
      add_beat(CMD_TEXT, SYM_A);
      add_beat(CMD_TEXT, CHAR_TOP);
      add_beat(CMD_END, '0);
      add_beat(CMD_CLEAR, CHAR_TOP);
      add_beat(CMD_TEXT, SYM_B);
      add_beat(CMD_END, SYM_A);
      add_beat(CMD_APPEND, SYM_A);
      add_beat(CMD_APPEND, SYM_A);
      settle();

      // Non-overlapping counting of a self-overlapping token.
      set_config(16'd0, 16'd2);
      repeat (4) add_beat(CMD_TEXT, SYM_A);
      add_beat(CMD_END, '0);
      settle();
      set_config(16'd0, 16'd3);
      repeat (4) add_beat(CMD_TEXT, SYM_A);
      add_beat(CMD_END, '0);
      settle();
      set_config(16'd0, 16'd0);
      repeat (2) add_beat(CMD_TEXT, SYM_A);
      add_beat(CMD_END, '0);
      settle();
      set_config(16'd5, 16'd1);
      repeat (3) add_beat(CMD_TEXT, SYM_A);
      add_beat(CMD_END, '0);
      settle();
      set_config(16'd3, 16'd1);
      repeat (3) add_beat(CMD_TEXT, SYM_A);
      add_beat(CMD_END, '0);
      settle();

      // The start register changes in the middle of a text.
      set_config(16'd0, 16'd1);
      add_beat(CMD_TEXT, SYM_X);
      add_beat(CMD_TEXT, SYM_A);
      settle();
      write_csr(CSR_START_CHAR, 16'd2);
      add_beat(CMD_TEXT, SYM_A);
      add_beat(CMD_END, '0);
      settle();
      set_config(16'hFFFF, 16'hFFFF);
      repeat (2) add_beat(CMD_TEXT, SYM_A);
      add_beat(CMD_END, '0);
      settle();

      // An overlong token sets overflow, and clearing the token leaves it set.
      set_config(16'd0, 16'd1);
      add_beat(CMD_CLEAR, '0);
      repeat (MAX_TOKEN_LEN + 1) add_beat(CMD_APPEND, SYM_FILL);
      add_beat(CMD_CLEAR, '0);
      add_beat(CMD_END, '0);
      repeat (MAX_TOKEN_LEN) add_beat(CMD_APPEND, SYM_FILL);
      repeat (MAX_TOKEN_LEN) add_beat(CMD_TEXT, SYM_FILL);
      add_beat(CMD_END, '0);
      settle();

      // A text two beats longer than the block can hold, then an empty text.
      add_beat(CMD_CLEAR, '0);
      add_beat(CMD_APPEND, SYM_A);
      add_beat(CMD_APPEND, SYM_B);
      repeat (MAX_TEXT_LEN + LONG_TEXT_EXTRA)
         add_beat(CMD_TEXT, $urandom_range(0, 1) ? SYM_A : SYM_B);
      add_beat(CMD_END, '0);
      add_beat(CMD_END, '0);
      settle();

      random_base = beats_queued;
      while (beats_queued - random_base < RANDOM_BEATS) begin
         r = $urandom_range(0, 99);
         if (r < 60) st = '0;
         else if (r < 90) st = CFG_W'($urandom_range(1, 10));
         else if (r < 97) st = CFG_W'($urandom_range(11, 40));
         else st = 16'hFFFF;
         r = $urandom_range(0, 99);
         if (r < 50) oc = 16'd1;
         else if (r < 85) oc = CFG_W'($urandom_range(2, 4));
         else if (r < 93) oc = '0;
         else if (r < 97) oc = CFG_W'($urandom_range(5, 20));
         else oc = 16'hFFFF;
         calm = ($urandom_range(0, 4) == 0);
         set_config(st, oc);

         if ($urandom_range(0, 2) != 0) begin
            n_sym = $urandom_range(1, 3);
            foreach (alphabet[i]) alphabet[i] = any_char();
            r = $urandom_range(0, 99);
            if (r < 3) n_len = 0;
            else if (r < 70) n_len = $urandom_range(1, 3);
            else if (r < 90) n_len = $urandom_range(4, 12);
            else if (r < 97) n_len = $urandom_range(13, MAX_TOKEN_LEN);
            else n_len = $urandom_range(MAX_TOKEN_LEN + 1, MAX_TOKEN_LEN + 3);
            add_beat(CMD_CLEAR, any_char());
            repeat (n_len) add_beat(CMD_APPEND, alphabet[$urandom_range(0, n_sym - 1)]);
         end

         n_texts = $urandom_range(1, 3);
         for (int t = 0; t < n_texts; t++) begin
            r = $urandom_range(0, 99);
            if (r < 5) n_chars = 0;
            else if (r < 90) n_chars = $urandom_range(1, 16);
            else n_chars = $urandom_range(17, 48);
            made = 0;
            while (made < n_chars) begin
               r = $urandom_range(0, 99);
               if (r < 25 && token_copy.size() > 0) begin
                  foreach (token_copy[k]) add_beat(CMD_TEXT, token_copy[k]);
                  made += token_copy.size();
               end else if (r < 35) begin
                  add_beat(CMD_TEXT, any_char());
                  made++;
               end else if (r < 38) begin
                  add_beat(CMD_W'($urandom_range(0, 3)), any_char());
                  made++;
               end else begin
                  add_beat(CMD_TEXT, alphabet[$urandom_range(0, n_sym - 1)]);
                  made++;
               end
            end
            if (t < n_texts - 1 || $urandom_range(0, 7) != 0) add_beat(CMD_END, any_char());
         end
         settle();
      end

      calm = 1'b0;
      add_beat(CMD_END, '0);
      settle();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Checked %0d result beats against %0d request beats,",
               results_checked, beats_accepted);
      $display("including a text past the length limit.");
      $display("Results by status: %0d found, %0d not found, %0d trivial, %0d overflow.",
               status_seen[STATUS_FOUND], status_seen[STATUS_NOT_FOUND],
               status_seen[STATUS_TRIVIAL], status_seen[STATUS_OVERFLOW]);
      if (error_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #(WATCHDOG_NS);
      $display("tb_top failed");
      $finish;
   end

endmodule
